// ===== rtl/core/tvcd_pkg.sv =====
// Shared types and constants of the tile variance contrast detector.
// No dependencies; compiled first and imported by every other file of the block.
`default_nettype none

package tvcd_pkg;

	// field widths
	localparam int LUMA_W   = 8;
	localparam int WSUM_W   = 18;
	localparam int RADIUS_W = 10;
	localparam int SPAN_W   = 5;
	localparam int LIMIT_W  = 16;

	// arithmetic widths
	localparam int SQR_W = 2 * SPAN_W;   // tile_span squared
	localparam int AA_W  = 2 * SQR_W;    // tile_span to the fourth
	localparam int DEV_W = WSUM_W;       // |p*A - S| never exceeds the corner sum range
	localparam int SUM_W = 46;           // deviation sum and bound

	// largest side the span field can express
	localparam int SPAN_SIDE_MAX = 2 ** SPAN_W;
	localparam int MAX_SIDE_DEF  = 32;

	// register reset values
	localparam int SPAN_RST   = 15;
	localparam int RADIUS_RST = 0;
	localparam int LIMIT_RST  = 25;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = LIMIT_W;

	localparam logic [CFG_IDX_W-1:0] CFG_TILE_SPAN  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_RADIUS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_VAR_LIMIT  = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BND_A2,
		ST_BND_LT,
		ST_BND_MUL,
		ST_PIX_PA,
		ST_PIX_SQ,
		ST_PIX_ACC
	} tvcd_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/tvcd_if.sv =====
// Valid/ready channel interfaces of the tile variance contrast detector:
// pixel input, result output and register writes. Uses tvcd_pkg widths.
`default_nettype none

interface tvcd_pix_if import tvcd_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [LUMA_W-1:0]   luma;
	logic [WSUM_W-1:0]   window_sum;
	logic [RADIUS_W-1:0] row_radius;

	modport source (output valid, output luma, output window_sum, output row_radius,
		input ready);
	modport sink (input valid, input luma, input window_sum, input row_radius,
		output ready);
endinterface

interface tvcd_res_if import tvcd_pkg::*; ();
	logic valid;
	logic ready;
	logic mark;
	logic skipped;

	modport source (output valid, output mark, output skipped, input ready);
	modport sink (input valid, input mark, input skipped, output ready);
endinterface

interface tvcd_cfg_if import tvcd_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/tile_variance_contrast_detect.sv =====
// Tile variance contrast detector: top level, one shared multiplier under a sequencer.
// Depends on tvcd_pkg and the channel interfaces in tvcd_if.sv.
//
// Usage: pixels of one square tile (side tile_span+1, clamped to MAX_SIDE) enter on pix
// in raster order; window_sum and row_radius are sampled with a tile's first pixel only.
// After the tile's last pixel one result leaves on res: skipped when row_radius is below
// min_radius, otherwise mark when sum (p*A - S)^2 exceeds limit*(N-1)*A^2, A = span^2.
// cfg writes a register (0 tile_span, 1 min_radius, 2 variance_limit) and
// is always ready; other indexes are ignored.
//
// Sequence: a pixel passes the transfer, p*A, square and accumulate steps in turn, and
// a tile's first pixel first passes the bound steps A^2, limit*(N-1) and their product,
// as they use the same multiplier. pix.ready is high only between pixels.
// The result is registered by the accumulate step of the last pixel and waits there.
// If res is stalled, the next pixel is still taken; only the accumulate step of a
// following tile end waits until the held result is transferred.
// Reset loads tile_span 15, min_radius 0, variance_limit 25 and starts a new tile.
`default_nettype none

module tile_variance_contrast_detect import tvcd_pkg::*; #(
	parameter int MAX_SIDE = MAX_SIDE_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	tvcd_pix_if.sink    pix,
	tvcd_res_if.source  res,
	tvcd_cfg_if.sink    cfg
);

	// the span field caps the side as well
	localparam int SIDE_EFF = (MAX_SIDE < SPAN_SIDE_MAX) ? MAX_SIDE : SPAN_SIDE_MAX;
	localparam int SIDE_W   = $clog2(SIDE_EFF + 1);
	localparam int CNT_W    = $clog2(SIDE_EFF * SIDE_EFF + 1);
	localparam int TM1_W    = $clog2(SIDE_EFF * SIDE_EFF);
	localparam int LT_W     = LIMIT_W + TM1_W;
	localparam int MA_W     = (LT_W > DEV_W) ? LT_W : DEV_W;
	localparam int MB_W     = AA_W;
	localparam int PROD_W   = MA_W + MB_W;

	localparam int SIDE_RST  = (SPAN_RST + 1 < SIDE_EFF) ? SPAN_RST + 1 : SIDE_EFF;
	localparam int TOTAL_RST = SIDE_RST * SIDE_RST;
	localparam int SQR_RST   = SPAN_RST * SPAN_RST;

	tvcd_state_t state_q, state_nx;

	// configuration and values derived from tile_span
	logic [SPAN_W-1:0]   span_q;
	logic [RADIUS_W-1:0] min_radius_q;
	logic [LIMIT_W-1:0]  limit_q;
	logic [SQR_W-1:0]    sqr_q;
	logic [CNT_W-1:0]    total_q;

	logic [SPAN_W-1:0]   span_w;
	logic [SPAN_W:0]     side_full;
	logic [SIDE_W-1:0]   side_w;

	// tile state
	logic [CNT_W-1:0]    cnt_q;
	logic [SUM_W-1:0]    sum_q;
	logic [SUM_W-1:0]    bound_q;
	logic [WSUM_W-1:0]   held_q;
	logic                gate_q;
	logic [LUMA_W-1:0]   luma_q;
	logic [AA_W-1:0]     aa_q;
	logic [PROD_W-1:0]   prod_q;

	// result register
	logic                out_valid_q;
	logic                mark_q;
	logic                skipped_q;

	// shared multiplier
	logic [MA_W-1:0]     ma;
	logic [MB_W-1:0]     mb;
	logic [PROD_W-1:0]   mul_p;

	logic [DEV_W-1:0]    pa;
	logic [DEV_W-1:0]    dev;
	logic [TM1_W-1:0]    tm1;
	logic [CNT_W:0]      cnt_inc;
	logic                tile_end;
	logic [SUM_W-1:0]    sum_next;
	logic                pix_xfer;
	logic                out_free;
	logic                acc_go;

	assign pix_xfer = pix.valid && pix.ready;
	assign out_free = !out_valid_q || res.ready;

	// side and count of the tile from a new span
	assign span_w    = cfg.data[SPAN_W-1:0];
	assign side_full = {1'b0, span_w} + (SPAN_W + 1)'(1);
	assign side_w    = (side_full > (SPAN_W + 1)'(SIDE_EFF)) ? SIDE_W'(SIDE_EFF)
		: SIDE_W'(side_full);

	assign pa       = prod_q[DEV_W-1:0];
	assign dev      = (pa >= held_q) ? (pa - held_q) : (held_q - pa);
	assign tm1      = TM1_W'(total_q - CNT_W'(1));
	assign cnt_inc  = {1'b0, cnt_q} + (CNT_W + 1)'(1);
	assign tile_end = cnt_inc >= {1'b0, total_q};
	assign sum_next = sum_q + SUM_W'(prod_q[2*DEV_W-1:0]);

	// operand select for the one multiplier
	always_comb begin
		ma = '0;
		mb = '0;
		unique case (state_q)
			ST_BND_A2: begin
				ma = MA_W'(sqr_q);
				mb = MB_W'(sqr_q);
			end
			ST_BND_LT: begin
				ma = MA_W'(limit_q);
				mb = MB_W'(tm1);
			end
			ST_BND_MUL: begin
				ma = MA_W'(prod_q[LT_W-1:0]);
				mb = aa_q;
			end
			ST_PIX_PA: begin
				ma = MA_W'(luma_q);
				mb = MB_W'(sqr_q);
			end
			ST_PIX_SQ: begin
				ma = MA_W'(dev);
				mb = MB_W'(dev);
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	assign mul_p = PROD_W'(ma) * PROD_W'(mb);

	// sequencer outputs
	always_comb begin
		pix.ready = (state_q == ST_IDLE);
		acc_go    = (state_q == ST_PIX_ACC) && (!tile_end || out_free);
	end

	// sequencer next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (pix_xfer) begin
					state_nx = (cnt_q == '0) ? ST_BND_A2 : ST_PIX_PA;
				end
			end
			ST_BND_A2:  state_nx = ST_BND_LT;
			ST_BND_LT:  state_nx = ST_BND_MUL;
			ST_BND_MUL: state_nx = ST_PIX_PA;
			ST_PIX_PA:  state_nx = ST_PIX_SQ;
			ST_PIX_SQ:  state_nx = ST_PIX_ACC;
			ST_PIX_ACC: begin
				if (acc_go) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// register writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_q       <= SPAN_W'(SPAN_RST);
			min_radius_q <= RADIUS_W'(RADIUS_RST);
			limit_q      <= LIMIT_W'(LIMIT_RST);
			sqr_q        <= SQR_W'(SQR_RST);
			total_q      <= CNT_W'(TOTAL_RST);
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				CFG_TILE_SPAN: begin
					span_q  <= span_w;
					sqr_q   <= SQR_W'(span_w) * SQR_W'(span_w);
					total_q <= CNT_W'(side_w) * CNT_W'(side_w);
				end
				CFG_MIN_RADIUS: min_radius_q <= cfg.data[RADIUS_W-1:0];
				CFG_VAR_LIMIT:  limit_q <= cfg.data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// tile count, deviation sum and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc_go && tile_end) begin
				out_valid_q <= 1'b1;
			end else if (res.valid && res.ready) begin
				out_valid_q <= 1'b0;
			end
			if (acc_go) begin
				if (tile_end) begin
					cnt_q <= '0;
					sum_q <= '0;
				end else begin
					cnt_q <= cnt_inc[CNT_W-1:0];
					sum_q <= sum_next;
				end
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (pix_xfer) begin
			luma_q <= pix.luma;
			if (cnt_q == '0) begin
				held_q <= pix.window_sum;
				gate_q <= pix.row_radius < min_radius_q;
			end
		end
		unique case (state_q)
			ST_BND_A2, ST_PIX_PA, ST_PIX_SQ: prod_q <= mul_p;
			ST_BND_LT: begin
				aa_q   <= prod_q[AA_W-1:0];
				prod_q <= mul_p;
			end
			// a one-pixel tile has no defined mean, so it never marks
			ST_BND_MUL: bound_q <= (span_q == '0) ? '1 : SUM_W'(mul_p);
			default: ;
		endcase
		if (acc_go && tile_end) begin
			mark_q    <= !gate_q && (sum_next > bound_q);
			skipped_q <= gate_q;
		end
	end

	assign res.valid   = out_valid_q;
	assign res.mark    = mark_q;
	assign res.skipped = skipped_q;

	// a result only appears from the accumulate step
	a_res_from_acc: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_PIX_ACC))
		else $error("result raised outside the accumulate step");

	// a tile's first pixel always builds the bound first
	a_first_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_xfer && cnt_q == '0) |=> state_q == ST_BND_A2)
		else $error("first pixel skipped the bound sequence");

	// a held result is never overwritten by the next tile end
	a_acc_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PIX_ACC && tile_end && res.valid && !res.ready)
		|=> state_q == ST_PIX_ACC)
		else $error("tile end passed a stalled result");

	// mark and skipped exclude each other
	a_mark_skip: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> !(res.mark && res.skipped))
		else $error("mark set on a skipped tile");

endmodule

`default_nettype wire

// ===== tb/sv/tile_variance_contrast_detect_test.sv =====
// Self-checking bench for tile_variance_contrast_detect: a directed table of pixels and
// register writes, then random tiles under random stalls, checked against an in-bench model.
// Depends on tvcd_pkg, the channel interfaces in tvcd_if.sv and the block itself.
`default_nettype none

module tile_variance_contrast_detect_test;
	import tvcd_pkg::*;

	localparam int HALF_PERIOD    = 6;
	localparam int RESET_CYCLES   = 5;
	localparam int SETTLE_CYCLES  = 16;
	localparam int HOLD_CYCLES    = 400;
	localparam int TIMEOUT_CYCLES = 500000;
	localparam int PIXEL_TARGET   = 1500;
	localparam int VERDICT_TARGET = 60;
	localparam int IDLE_PCT       = 31;
	localparam int SIDE_LIMIT     = MAX_SIDE_DEF;
	localparam int SPAN_MAX       = 31;
	localparam int RADIUS_MAX     = 1023;
	localparam int LIMIT_MAX      = 65535;
	localparam int WSUM_MAX       = 245055;
	localparam int PLAN_LEN       = 30;
	localparam bit [63:0] BOUND_MAX = (64'd1 << SUM_W) - 64'd1;

	typedef struct packed {
		logic mark;
		logic skipped;
	} verdict_t;

	typedef enum logic { DO_WRITE, DO_PIXEL } step_op_t;

	typedef struct packed {
		step_op_t              op;
		logic [CFG_IDX_W-1:0]  reg_idx;
		logic [CFG_DATA_W-1:0] reg_val;
		logic [LUMA_W-1:0]     luma;
		logic [WSUM_W-1:0]     wsum;
		logic [RADIUS_W-1:0]   radius;
		logic                  typed;
		verdict_t              want;
	} step_t;

	logic clk;
	logic arst_n;

	tvcd_pix_if pix_ch ();
	tvcd_res_if res_ch ();
	tvcd_cfg_if cfg_ch ();

	tile_variance_contrast_detect uut (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	// tile model state and its copy of the registers
	bit [SPAN_W-1:0]   span_cfg;
	bit [RADIUS_W-1:0] min_radius_cfg;
	bit [LIMIT_W-1:0]  limit_cfg;
	bit [63:0]         dev_acc;
	bit [63:0]         bound_held;
	int unsigned       px_taken;
	bit [WSUM_W-1:0]   corner_held;
	bit                skip_held;

	verdict_t verdicts_due [$];

	int errors        = 0;
	int pixels_sent   = 0;
	int verdicts_seen = 0;
	int marks_seen    = 0;
	int skips_seen    = 0;
	int in_idle_pct   = IDLE_PCT;
	int out_idle_pct  = IDLE_PCT;
	int hold_asks     = 0;
	int hold_served   = 0;

	step_t plan [PLAN_LEN] = '{
		// one-pixel tiles: mean undefined, never marked
		'{DO_WRITE, CFG_TILE_SPAN,  16'd0,     8'd0,   18'd0,      10'd0,    1'b0, '{1'b0, 1'b0}},
		'{DO_PIXEL, CFG_TILE_SPAN,  16'd0,     8'd255, 18'd0,      10'd0,    1'b1, '{1'b0, 1'b0}},
		'{DO_WRITE, CFG_MIN_RADIUS, 16'd1023,  8'd0,   18'd0,      10'd0,    1'b0, '{1'b0, 1'b0}},
		'{DO_PIXEL, CFG_TILE_SPAN,  16'd0,     8'd0,   18'd245055, 10'd1022, 1'b1, '{1'b0, 1'b1}},
		'{DO_PIXEL, CFG_TILE_SPAN,  16'd0,     8'd128, 18'd100000, 10'd1023, 1'b1, '{1'b0, 1'b0}},
		'{DO_WRITE, CFG_MIN_RADIUS, 16'd0,     8'd0,   18'd0,      10'd0,    1'b0, '{1'b0, 1'b0}},
		'{DO_WRITE, CFG_TILE_SPAN,  16'd1,     8'd0,   18'd0,      10'd0,    1'b0, '{1'b0, 1'b0}},
		'{DO_WRITE, CFG_VAR_LIMIT,  16'd0,     8'd0,   18'd0,      10'd0,    1'b0, '{1'b0, 1'b0}},
		// flat tile against a zero limit: not above, so no mark
		'{DO_PIXEL, CFG_TILE_SPAN,  16'd0,     8'd0,   18'd0,      10'd0,    1'b0, '{1'b0, 1'b0}},
		'{DO_PIXEL, CFG_TILE_SPAN,  16'd0,     8'd0,   18'd0,      10'd0,    1'b0, '{1'b0, 1'b0}},
		'{DO_PIXEL, CFG_TILE_SPAN,  16'd0,     8'd0,   18'd0,      10'd0,    1'b0, '{1'b0, 1'b0}},
		'{DO_PIXEL, CFG_TILE_SPAN,  16'd0,     8'd0,   18'd0,      10'd0,    1'b1, '{1'b0, 1'b0}},
		'{DO_PIXEL, CFG_TILE_SPAN,  16'd0,     8'd255, 18'd0,      10'd512,  1'b0, '{1'b0, 1'b0}},
		'{DO_PIXEL, CFG_TILE_SPAN,  16'd0,     8'd0,   18'd0,      10'd0,    1'b0, '{1'b0, 1'b0}},
		'{DO_PIXEL, CFG_TILE_SPAN,  16'd0,     8'd255, 18'd0,      10'd0,    1'b0, '{1'b0, 1'b0}},
		'{DO_PIXEL, CFG_TILE_SPAN,  16'd0,     8'd0,   18'd0,      10'd0,    1'b1, '{1'b1, 1'b0}},
		'{DO_WRITE, CFG_VAR_LIMIT,  16'd65535, 8'd0,   18'd0,      10'd0,    1'b0, '{1'b0, 1'b0}},
		'{DO_PIXEL, CFG_TILE_SPAN,  16'd0,     8'd255, 18'd245055, 10'd1023, 1'b0, '{1'b0, 1'b0}},
		'{DO_PIXEL, CFG_TILE_SPAN,  16'd0,     8'd0,   18'd0,      10'd0,    1'b0, '{1'b0, 1'b0}},
		'{DO_PIXEL, CFG_TILE_SPAN,  16'd0,     8'd255, 18'd0,      10'd0,    1'b0, '{1'b0, 1'b0}},
		'{DO_PIXEL, CFG_TILE_SPAN,  16'd0,     8'd0,   18'd0,      10'd0,    1'b0, '{1'b0, 1'b0}},
		// span shrinks mid-tile, so the next pixel closes the tile
		'{DO_WRITE, CFG_VAR_LIMIT,  16'd25,    8'd0,   18'd0,      10'd0,    1'b0, '{1'b0, 1'b0}},
		'{DO_WRITE, CFG_TILE_SPAN,  16'd3,     8'd0,   18'd0,      10'd0,    1'b0, '{1'b0, 1'b0}},
		'{DO_PIXEL, CFG_TILE_SPAN,  16'd0,     8'd10,  18'd900,    10'd7,    1'b0, '{1'b0, 1'b0}},
		'{DO_PIXEL, CFG_TILE_SPAN,  16'd0,     8'd200, 18'd0,      10'd0,    1'b0, '{1'b0, 1'b0}},
		'{DO_PIXEL, CFG_TILE_SPAN,  16'd0,     8'd30,  18'd0,      10'd0,    1'b0, '{1'b0, 1'b0}},
		'{DO_PIXEL, CFG_TILE_SPAN,  16'd0,     8'd180, 18'd0,      10'd0,    1'b0, '{1'b0, 1'b0}},
		'{DO_PIXEL, CFG_TILE_SPAN,  16'd0,     8'd90,  18'd0,      10'd0,    1'b0, '{1'b0, 1'b0}},
		'{DO_WRITE, CFG_TILE_SPAN,  16'd1,     8'd0,   18'd0,      10'd0,    1'b0, '{1'b0, 1'b0}},
		'{DO_PIXEL, CFG_TILE_SPAN,  16'd0,     8'd77,  18'd0,      10'd0,    1'b0, '{1'b0, 1'b0}}
	};

	always begin
		clk = 1'b0;
		#HALF_PERIOD;
		clk = 1'b1;
		#HALF_PERIOD;
	end

	function automatic int unsigned tile_length();
		int unsigned side;
		side = int'(span_cfg) + 1;
		if (side > SIDE_LIMIT) side = SIDE_LIMIT;
		return side * side;
	endfunction

	// folds one pixel into the running tile; returns 1 when the tile closes
	function automatic bit fold_pixel(input bit [LUMA_W-1:0] luma, input bit [WSUM_W-1:0] wsum,
			input bit [RADIUS_W-1:0] radius, output verdict_t v);
		bit [63:0] a;
		bit [63:0] total;
		bit [63:0] b;
		bit [63:0] pa;
		bit [63:0] s;
		bit [63:0] d;
		a = 64'(span_cfg) * 64'(span_cfg);
		total = 64'(tile_length());
		v = '0;
		if (px_taken == 0) begin
			corner_held = wsum;
			skip_held = radius < min_radius_cfg;
			dev_acc = '0;
			if (span_cfg == 0) begin
				bound_held = BOUND_MAX;
			end else begin
				b = 64'(limit_cfg) * (total - 64'd1) * a * a;
				bound_held = (b > BOUND_MAX) ? BOUND_MAX : b;
			end
		end
		pa = 64'(luma) * a;
		s = 64'(corner_held);
		d = (pa >= s) ? pa - s : s - pa;
		dev_acc = (dev_acc + d * d) & BOUND_MAX;
		px_taken = px_taken + 1;
		if (64'(px_taken) >= total) begin
			v.skipped = skip_held;
			v.mark = !skip_held && (dev_acc > bound_held);
			px_taken = 0;
			dev_acc = '0;
			return 1'b1;
		end
		px_taken = px_taken & 32'h3FF;
		return 1'b0;
	endfunction

	// drop the pixel offer and let the block drain before touching registers
	task automatic settle();
		@(negedge clk);
		pix_ch.valid = 1'b0;
		while (verdicts_due.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		settle();
		cfg_ch.valid = 1'b1;
		cfg_ch.index = idx;
		cfg_ch.data = val;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			CFG_TILE_SPAN:  span_cfg = val[SPAN_W-1:0];
			CFG_MIN_RADIUS: min_radius_cfg = val[RADIUS_W-1:0];
			CFG_VAR_LIMIT:  limit_cfg = val[LIMIT_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	task automatic offer_pixel(input logic [LUMA_W-1:0] luma, input logic [WSUM_W-1:0] wsum,
			input logic [RADIUS_W-1:0] radius, input bit typed, input verdict_t want);
		verdict_t got;
		@(negedge clk);
		while ($urandom_range(99) < in_idle_pct) begin
			pix_ch.valid = 1'b0;
			@(negedge clk);
		end
		pix_ch.valid = 1'b1;
		pix_ch.luma = luma;
		pix_ch.window_sum = wsum;
		pix_ch.row_radius = radius;
		do @(posedge clk); while (!pix_ch.ready);
		pixels_sent++;
		if (fold_pixel(luma, wsum, radius, got)) verdicts_due.push_back(typed ? want : got);
	endtask

	// result sink: random stalls, plus a long hold-off on request
	initial begin
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_asks != hold_served) begin
				res_ch.ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_served++;
			end
			res_ch.ready = ($urandom_range(99) >= out_idle_pct);
		end
	end

	always @(posedge clk) begin : verdict_check
		verdict_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			verdicts_seen++;
			if (res_ch.mark) marks_seen++;
			if (res_ch.skipped) skips_seen++;
			if (verdicts_due.size() == 0) begin
				errors++;
				$display("%0t: result with none due: expected nothing, got mark=%0b skipped=%0b",
					$time, res_ch.mark, res_ch.skipped);
			end else begin
				want = verdicts_due.pop_front();
				if (res_ch.mark !== want.mark) begin
					errors++;
					$display("%0t: mark expected %0b, got %0b", $time, want.mark, res_ch.mark);
				end
				if (res_ch.skipped !== want.skipped) begin
					errors++;
					$display("%0t: skipped expected %0b, got %0b", $time, want.skipped,
						res_ch.skipped);
				end
			end
		end
	end

	initial begin
		int phase;
		int span_pick;
		int radius_pick;
		int limit_pick;
		int tiles;
		int count;
		int a_now;
		int lum;
		int w;
		int rr;
		int tile_center;
		int tile_spread;
		bit tile_noise;
		logic [WSUM_W-1:0] tile_wsum;
		logic [RADIUS_W-1:0] tile_radius;

		pix_ch.valid = 1'b0;
		pix_ch.luma = '0;
		pix_ch.window_sum = '0;
		pix_ch.row_radius = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_TILE_SPAN;
		cfg_ch.data = '0;
		arst_n = 1'b0;
		span_cfg = SPAN_RST;
		min_radius_cfg = RADIUS_RST;
		limit_cfg = LIMIT_RST;
		dev_acc = '0;
		bound_held = '0;
		px_taken = 0;
		corner_held = '0;
		skip_held = 1'b0;
		tile_center = 0;
		tile_spread = 0;
		tile_noise = 1'b0;
		tile_wsum = '0;
		tile_radius = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (plan[i]) begin
			if (plan[i].op == DO_WRITE)
				write_reg(plan[i].reg_idx, plan[i].reg_val);
			else
				offer_pixel(plan[i].luma, plan[i].wsum, plan[i].radius, plan[i].typed,
					plan[i].want);
		end

		phase = 0;
		while (phase < 6 || pixels_sent < PIXEL_TARGET || verdicts_seen < VERDICT_TARGET) begin
			// phase 1 fills the block under a held sink, phase 2 runs one largest tile
			if (phase == 1) begin
				span_pick = 1;
			end else if (phase == 2) begin
				span_pick = SPAN_MAX;
			end else begin
				span_pick = $urandom_range(99);
				if (span_pick < 10) span_pick = 0;
				else if (span_pick < 75) span_pick = $urandom_range(3, 1);
				else if (span_pick < 92) span_pick = $urandom_range(7, 4);
				else span_pick = $urandom_range(15, 8);
			end
			radius_pick = $urandom_range(9);
			if (radius_pick < 4) radius_pick = 0;
			else if (radius_pick == 4) radius_pick = RADIUS_MAX;
			else radius_pick = $urandom_range(RADIUS_MAX);
			limit_pick = $urandom_range(9);
			if (limit_pick == 0) limit_pick = 0;
			else if (limit_pick == 1) limit_pick = LIMIT_MAX;
			else if (limit_pick < 5) limit_pick = 25;
			else if (limit_pick < 8) limit_pick = $urandom_range(400);
			else limit_pick = $urandom_range(LIMIT_MAX);

			// a tile left open by the last phase sees these writes mid-tile
			write_reg(CFG_TILE_SPAN, CFG_DATA_W'(span_pick));
			write_reg(CFG_MIN_RADIUS, CFG_DATA_W'(radius_pick));
			write_reg(CFG_VAR_LIMIT, CFG_DATA_W'(limit_pick));

			in_idle_pct = (phase == 4) ? 0 : IDLE_PCT;
			out_idle_pct = (phase == 4) ? 0 : IDLE_PCT;
			if (phase == 1) hold_asks++;

			count = int'(tile_length());
			if (count > 64) tiles = 1;
			else if (span_pick == 0) tiles = $urandom_range(40, 10);
			else tiles = $urandom_range(8, 2);
			if (phase == 4) tiles = tiles * 4;
			if (count > 1 && count <= 64 && $urandom_range(3) == 0)
				count = tiles * count + int'($urandom_range(count - 1, 1));
			else
				count = tiles * count;

			repeat (count) begin
				if (px_taken == 0) begin
					a_now = int'(span_cfg) * int'(span_cfg);
					tile_noise = ($urandom_range(99) < 25);
					tile_center = $urandom_range(255);
					case ($urandom_range(5))
						0: tile_spread = 0;
						1: tile_spread = 1;
						2: tile_spread = 3;
						3: tile_spread = 8;
						4: tile_spread = 30;
						default: tile_spread = 128;
					endcase
					if (tile_noise || a_now == 0) begin
						tile_wsum = WSUM_W'($urandom_range(WSUM_MAX));
					end else begin
						// corner sum consistent with the tile's mean, with a little jitter
						w = tile_center * a_now + int'($urandom_range(a_now)) - a_now / 2;
						if (w < 0) w = 0;
						if (w > WSUM_MAX) w = WSUM_MAX;
						tile_wsum = WSUM_W'(w);
					end
					if ($urandom_range(1) == 0) begin
						tile_radius = RADIUS_W'($urandom_range(RADIUS_MAX));
					end else begin
						rr = int'(min_radius_cfg) + int'($urandom_range(2)) - 1;
						if (rr < 0) rr = 0;
						if (rr > RADIUS_MAX) rr = RADIUS_MAX;
						tile_radius = RADIUS_W'(rr);
					end
				end
				if (tile_noise) begin
					lum = $urandom_range(255);
				end else begin
					lum = tile_center + int'($urandom_range(2 * tile_spread)) - tile_spread;
					if (lum < 0) lum = 0;
					if (lum > 255) lum = 255;
				end
				offer_pixel(LUMA_W'(lum), tile_wsum, tile_radius, 1'b0, '0);
			end
			phase++;
		end

		settle();
		$display("covered %0d pixels, %0d tile verdicts (%0d marked, %0d skipped), %0d settings",
			pixels_sent, verdicts_seen, marks_seen, skips_seen, phase);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#(TIMEOUT_CYCLES * 2 * HALF_PERIOD);
		$display("FAIL");
		$finish;
	end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/core/tvcd_pkg.sv
rtl/core/tvcd_if.sv
rtl/core/tile_variance_contrast_detect.sv
tb/sv/tile_variance_contrast_detect_test.sv
